@@ src/image_bilinear_bicubic_sampler_macros.svh @@
// Assertion macros used by the sampler's back end.
`ifndef IMAGE_BILINEAR_BICUBIC_SAMPLER_MACROS_SVH
`define IMAGE_BILINEAR_BICUBIC_SAMPLER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define IBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sampler assertion failed");
// Next-cycle implication, disabled while reset is held.
`define IBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sampler assertion failed");
`else
`define IBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/ibs_pkg.sv @@
// Package of types and constants for the image sampler.
package ibs_pkg;

    localparam int MAX_ROWS_DEF  = 512;
    localparam int MAX_COLS_DEF  = 512;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam int OP_W   = 2;
    localparam int PIX_W  = 9;
    localparam int SMP_W  = 17;
    localparam int CH_W   = 8;
    localparam int RGB_W  = 3 * CH_W;
    localparam int SIZE_W = 10;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_BILINEAR = 2'd0,
        MODE_BICUBIC  = 2'd1
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_WRITE = 3'd0,
        K_READ  = 3'd1,
        K_BILIN = 3'd2,
        K_BICUB = 3'd3,
        K_BLACK = 3'd4
    } t_kind;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [MODE_W-1:0] mode;
    } t_cfg;

endpackage

@@ src/ibs_ifs.sv @@
// Channel interfaces: sample words in, colour words out, configuration writes.
interface ibs_smp_if;
    logic                            valid;
    logic                            ready;
    logic [ibs_pkg::OP_W-1:0]        op;
    logic [ibs_pkg::PIX_W-1:0]       pixel_row;
    logic [ibs_pkg::PIX_W-1:0]       pixel_col;
    logic [ibs_pkg::SMP_W-1:0]       sample_row;
    logic [ibs_pkg::SMP_W-1:0]       sample_col;
    logic [ibs_pkg::CH_W-1:0]        red;
    logic [ibs_pkg::CH_W-1:0]        green;
    logic [ibs_pkg::CH_W-1:0]        blue;
    modport source (output valid, op, pixel_row, pixel_col, sample_row, sample_col,
                    red, green, blue, input ready);
    modport sink   (input valid, op, pixel_row, pixel_col, sample_row, sample_col,
                    red, green, blue, output ready);
endinterface

interface ibs_res_if;
    logic                     valid;
    logic                     ready;
    logic [ibs_pkg::CH_W-1:0] out_red;
    logic [ibs_pkg::CH_W-1:0] out_green;
    logic [ibs_pkg::CH_W-1:0] out_blue;
    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface ibs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ibs_pkg::IDX_W-1:0]  index;
    logic [ibs_pkg::SIZE_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ibs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ibs_ram #(
    parameter int W = 24,
    parameter int D = 262144
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/ibs_queue.sv @@
// Short command queue between the front and the back.
module ibs_queue #(
    parameter type T_CMD = logic,
    parameter int  DEPTH = ibs_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T_CMD i_push_cmd,
    output logic o_push_ready,
    input  logic i_pop,
    output logic o_pop_valid,
    output T_CMD o_pop_cmd
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T_CMD          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          c_push;
    logic          c_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign c_push       = i_push && o_push_ready;
    assign c_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) begin
                r_mem[r_wp] <= i_push_cmd;
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (c_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (c_push && !c_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (c_pop && !c_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ src/ibs_front.sv @@
// Front end: takes input words, splits sample positions and classifies them.
module ibs_front #(
    parameter type T_CMD     = logic,
    parameter int  FRAC_BITS = ibs_pkg::FRAC_BITS_DEF,
    parameter int  CW        = 14
) (
    ibs_smp_if.sink                   i_smp,
    input  logic [ibs_pkg::MODE_W-1:0] i_mode,
    output logic                      o_push,
    output T_CMD                      o_cmd,
    input  logic                      i_push_ready
);
    localparam int RW = ibs_pkg::SMP_W + 1;
    localparam logic signed [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

    logic signed [RW-1:0] c_rr;
    logic signed [RW-1:0] c_rc;

    // Shift positions so that pixel centres sit on integers; the arithmetic
    // shift gives floor, so the position left of the first centre gets base -1.
    assign c_rr = $signed({1'b0, i_smp.sample_row}) - HALF;
    assign c_rc = $signed({1'b0, i_smp.sample_col}) - HALF;

    assign i_smp.ready = i_push_ready;

    always_comb begin
        o_push       = i_smp.valid;
        o_cmd.kind   = ibs_pkg::K_BLACK;
        o_cmd.base_r = CW'(c_rr >>> FRAC_BITS);
        o_cmd.base_c = CW'(c_rc >>> FRAC_BITS);
        o_cmd.frac_r = c_rr[FRAC_BITS-1:0];
        o_cmd.frac_c = c_rc[FRAC_BITS-1:0];
        o_cmd.pix    = {i_smp.red, i_smp.green, i_smp.blue};
        unique case (ibs_pkg::t_op'(i_smp.op))
            ibs_pkg::OP_WRITE, ibs_pkg::OP_READ: begin
                o_cmd.kind = (ibs_pkg::t_op'(i_smp.op) == ibs_pkg::OP_WRITE) ?
                             ibs_pkg::K_WRITE : ibs_pkg::K_READ;
                o_cmd.base_r = CW'(i_smp.pixel_row);
                o_cmd.base_c = CW'(i_smp.pixel_col);
            end
            ibs_pkg::OP_SAMPLE: begin
                unique case (ibs_pkg::t_mode'(i_mode))
                    ibs_pkg::MODE_BILINEAR: o_cmd.kind = ibs_pkg::K_BILIN;
                    ibs_pkg::MODE_BICUBIC: begin
                        // The cubic window starts one pixel up and left.
                        o_cmd.kind   = ibs_pkg::K_BICUB;
                        o_cmd.base_r = CW'(c_rr >>> FRAC_BITS) - CW'(1);
                        o_cmd.base_c = CW'(c_rc >>> FRAC_BITS) - CW'(1);
                    end
                    default: o_cmd.kind = ibs_pkg::K_BLACK;
                endcase
            end
            default: o_push = 1'b0;
        endcase
    end
endmodule

@@ src/ibs_back.sv @@
// Back end: fetches neighbours, runs the interpolation and holds the result.
`include "image_bilinear_bicubic_sampler_macros.svh"
module ibs_back #(
    parameter type T_CMD     = logic,
    parameter int  MAX_ROWS  = ibs_pkg::MAX_ROWS_DEF,
    parameter int  MAX_COLS  = ibs_pkg::MAX_COLS_DEF,
    parameter int  FRAC_BITS = ibs_pkg::FRAC_BITS_DEF,
    parameter int  CW        = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ibs_pkg::t_cfg             i_cfg,
    input  logic                      i_q_valid,
    input  T_CMD                      i_q_cmd,
    output logic                      o_q_pop,
    ibs_res_if.source                 o_res
);
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RB = $clog2(MAX_ROWS);
    localparam int CB = $clog2(MAX_COLS);
    localparam int VW = FRAC_BITS + 18;
    localparam int PW = VW + FRAC_BITS + 1;
    localparam int CH = ibs_pkg::CH_W;
    localparam logic signed [PW-1:0] HALF1 = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF2 = PW'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [PW-1:0] SAT_HI = PW'((1 << CH) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WAIT,
        S_CALC,
        S_OUT
    } t_state;

    t_state                  r_state;
    T_CMD                    r_cmd;
    logic [1:0]              r_i;
    logic [1:0]              r_j;
    logic [1:0]              r_step;
    logic                    r_col;
    logic                    r_pend;
    logic                    r_pend_in;
    logic signed [VW-1:0]    r_w  [3][4];
    logic signed [VW-1:0]    r_rv [3][4];
    logic signed [PW-1:0]    r_m  [3];
    logic [CH-1:0]           r_res [3];
    logic                    r_out_valid;
    logic [ibs_pkg::RGB_W-1:0] r_out;

    logic                    c_pop;
    ibs_pkg::t_kind          c_kind;
    logic signed [CW-1:0]    c_row;
    logic signed [CW-1:0]    c_col;
    logic [CW-1:0]           c_h;
    logic [CW-1:0]           c_w;
    logic                    c_in;
    logic [AW-1:0]           c_addr;
    logic                    c_we;
    logic                    c_re;
    logic [ibs_pkg::RGB_W-1:0] c_rdata;
    logic [1:0]              c_last;
    logic [1:0]              c_last_step;
    logic                    c_out_free;
    logic [FRAC_BITS-1:0]    c_d;
    logic signed [PW-1:0]    c_prod [3];
    logic signed [VW-1:0]    c_val  [3];
    logic [CH-1:0]           c_sat  [3];

    assign c_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop = c_pop;
    assign c_kind  = ibs_pkg::t_kind'(r_cmd.kind);

    // Tap position: the head of the queue while idle, otherwise window offsets.
    always_comb begin
        if (r_state == S_IDLE) begin
            c_row = i_q_cmd.base_r;
            c_col = i_q_cmd.base_c;
        end else begin
            c_row = r_cmd.base_r + CW'(r_i);
            c_col = r_cmd.base_c + CW'(r_j);
        end
        c_h = (int'(i_cfg.height) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(i_cfg.height);
        c_w = (int'(i_cfg.width) > MAX_COLS) ? CW'(MAX_COLS) : CW'(i_cfg.width);
        c_in = !c_row[CW-1] && !c_col[CW-1] && ($unsigned(c_row) < c_h)
            && ($unsigned(c_col) < c_w);
        c_addr = AW'(c_row[RB-1:0]) * AW'(MAX_COLS) + AW'(c_col[CB-1:0]);
    end

    assign c_we = c_pop && (ibs_pkg::t_kind'(i_q_cmd.kind) == ibs_pkg::K_WRITE) && c_in;
    assign c_re = (r_state == S_FETCH);

    ibs_ram #(
        .W(ibs_pkg::RGB_W),
        .D(MAX_ROWS * MAX_COLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_addr),
        .i_wdata (i_q_cmd.pix),
        .i_re    (c_re),
        .i_raddr (c_addr),
        .o_rdata (c_rdata)
    );

    always_comb begin
        unique case (c_kind)
            ibs_pkg::K_BICUB: c_last = 2'd3;
            ibs_pkg::K_BILIN: c_last = 2'd1;
            default:          c_last = 2'd0;
        endcase
        c_last_step = (c_kind == ibs_pkg::K_BICUB) ? 2'd3 : 2'd1;
        c_d = r_col ? r_cmd.frac_r : r_cmd.frac_c;
    end

    // One multiply per lane per cycle. The cubic runs as three multiply
    // steps and a final add; the linear blend as one multiply and an add.
    always_comb begin
        logic signed [VW-1:0] q0, q1, q2, q3, a, b, c, x;
        logic signed [PW-1:0] rm, fin, sum;
        for (int l = 0; l < 3; l++) begin
            q0 = r_col ? r_rv[l][0] : r_w[l][0];
            q1 = r_col ? r_rv[l][1] : r_w[l][1];
            q2 = r_col ? r_rv[l][2] : r_w[l][2];
            q3 = r_col ? r_rv[l][3] : r_w[l][3];
            a = q3 - q2;
            b = q1 - q0;
            c = q2 - q0;
            sum = r_m[l] + HALF1;
            rm = sum >>> FRAC_BITS;
            x = a;
            if (c_kind == ibs_pkg::K_BICUB) begin
                unique case (r_step)
                    2'd0:    x = a + b;
                    2'd1:    x = VW'(rm) - a - (b <<< 1);
                    default: x = VW'(rm) + c;
                endcase
                c_val[l] = VW'(rm) + q1;
                sum = PW'(c_val[l]) + HALF1;
                fin = sum >>> FRAC_BITS;
            end else begin
                c_val[l] = q2 + VW'(r_m[l] >>> FRAC_BITS);
                sum = r_m[l] + (PW'(q2) <<< FRAC_BITS) + HALF2;
                fin = sum >>> (2 * FRAC_BITS);
            end
            c_prod[l] = PW'(x) * PW'($signed({1'b0, c_d}));
            if (fin < 0) begin
                c_sat[l] = '0;
            end else if (fin > SAT_HI) begin
                c_sat[l] = '1;
            end else begin
                c_sat[l] = fin[CH-1:0];
            end
        end
    end

    assign c_out_free    = !r_out_valid || o_res.ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = r_out[3*CH-1:2*CH];
    assign o_res.out_green = r_out[2*CH-1:CH];
    assign o_res.out_blue  = r_out[CH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            r_pend    <= c_re;
            r_pend_in <= c_in;
            if ((r_state == S_OUT) && c_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_pend) begin
                for (int l = 0; l < 3; l++) begin
                    for (int t = 0; t < 3; t++) begin
                        r_w[l][t] <= r_w[l][t+1];
                    end
                    r_w[l][3] <= r_pend_in ?
                        VW'($signed({1'b0, c_rdata[ibs_pkg::RGB_W-1-CH*l -: CH],
                                     {FRAC_BITS{1'b0}}})) : '0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (c_pop) begin
                        r_cmd  <= i_q_cmd;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_step <= '0;
                        r_col  <= 1'b0;
                        unique case (ibs_pkg::t_kind'(i_q_cmd.kind))
                            ibs_pkg::K_WRITE: r_state <= S_IDLE;
                            ibs_pkg::K_READ, ibs_pkg::K_BILIN, ibs_pkg::K_BICUB:
                                r_state <= S_FETCH;
                            default: begin
                                for (int l = 0; l < 3; l++) begin
                                    r_res[l] <= '0;
                                end
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == c_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_step <= '0;
                    if (c_kind == ibs_pkg::K_READ) begin
                        for (int l = 0; l < 3; l++) begin
                            r_res[l] <= r_pend_in ?
                                c_rdata[ibs_pkg::RGB_W-1-CH*l -: CH] : '0;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    for (int l = 0; l < 3; l++) begin
                        r_m[l] <= c_prod[l];
                    end
                    r_step <= (r_step == c_last_step) ? 2'd0 : r_step + 1'b1;
                    if (r_step == c_last_step) begin
                        if (r_col) begin
                            for (int l = 0; l < 3; l++) begin
                                r_res[l] <= c_sat[l];
                            end
                            r_state <= S_OUT;
                        end else begin
                            for (int l = 0; l < 3; l++) begin
                                for (int t = 0; t < 3; t++) begin
                                    r_rv[l][t] <= r_rv[l][t+1];
                                end
                                r_rv[l][3] <= c_val[l];
                            end
                            if (r_i == c_last) begin
                                r_col <= 1'b1;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_j     <= '0;
                                r_state <= S_FETCH;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (c_out_free) begin
                        r_out   <= {r_res[0], r_res[1], r_res[2]};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Store writes happen only when a command leaves the queue.
    `IBS_ASSERT_NOW(a_write_idle, i_clk, i_rst_n, c_we, r_state == S_IDLE)
    // Read data arrives only while the window is being filled.
    `IBS_ASSERT_NOW(a_pend_fetch, i_clk, i_rst_n, r_pend,
        (r_state == S_FETCH) || (r_state == S_WAIT))
    // A finished result with a free output register is shown next cycle.
    `IBS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && c_out_free,
        r_out_valid && (r_state == S_IDLE))
endmodule

@@ src/image_bilinear_bicubic_sampler.sv @@
// Top level of the RGB image store with bilinear and bicubic sampling.
//
//  channel  | modport | direction | word
//  ---------+---------+-----------+------------------------------------------
//  i_smp    | sink    | in        | op, pixel row/col, sample row/col, RGB
//  o_res    | source  | out       | out_red, out_green, out_blue
//  i_cfg    | sink    | in        | register index, write data
//
// A bilinear or bicubic sample keeps the back end busy longest: the single read
// port of the pixel store yields one neighbour a cycle, and each lane has one
// multiplier. A word with an unknown operation is dropped by the front.
// The front and the back are parted by a two-word queue, so the input side
// can take up to two words while the back works or its result waits.
// i_rst_n is synchronous and active low; the pixel store is not cleared.
// The result sits in an output register until it is taken.
module image_bilinear_bicubic_sampler #(
    parameter int MAX_ROWS  = ibs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = ibs_pkg::MAX_COLS_DEF,
    parameter int FRAC_BITS = ibs_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibs_smp_if.sink    i_smp,
    ibs_res_if.source  o_res,
    ibs_cfg_if.sink    i_cfg
);
    // Signed coordinate width: covers the largest base plus window offsets
    // and the negative neighbours left of the image.
    localparam int CW = (ibs_pkg::SMP_W - FRAC_BITS + 3 > 14) ?
                        ibs_pkg::SMP_W - FRAC_BITS + 3 : 14;

    typedef struct packed {
        ibs_pkg::t_kind              kind;
        logic signed [CW-1:0]        base_r;
        logic signed [CW-1:0]        base_c;
        logic [FRAC_BITS-1:0]        frac_r;
        logic [FRAC_BITS-1:0]        frac_c;
        logic [ibs_pkg::RGB_W-1:0]   pix;
    } t_cmd;

    ibs_pkg::t_cfg r_cfg;
    logic          c_push;
    logic          c_push_ready;
    t_cmd          c_push_cmd;
    logic          c_pop;
    logic          c_pop_valid;
    t_cmd          c_pop_cmd;

    // Configuration registers; writes are always taken, unknown indexes dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= ibs_pkg::SIZE_W'(512);
            r_cfg.height <= ibs_pkg::SIZE_W'(512);
            r_cfg.mode   <= ibs_pkg::MODE_BILINEAR;
        end else if (i_cfg.valid) begin
            unique case (ibs_pkg::t_cfg_idx'(i_cfg.index))
                ibs_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg.data;
                ibs_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg.data;
                ibs_pkg::CFG_MODE:   r_cfg.mode   <= i_cfg.data[ibs_pkg::MODE_W-1:0];
                default:             r_cfg        <= r_cfg;
            endcase
        end
    end

    ibs_front #(
        .T_CMD     (t_cmd),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_front (
        .i_smp        (i_smp),
        .i_mode       (r_cfg.mode),
        .o_push       (c_push),
        .o_cmd        (c_push_cmd),
        .i_push_ready (c_push_ready)
    );

    ibs_queue #(
        .T_CMD (t_cmd),
        .DEPTH (ibs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (c_push),
        .i_push_cmd   (c_push_cmd),
        .o_push_ready (c_push_ready),
        .i_pop        (c_pop),
        .o_pop_valid  (c_pop_valid),
        .o_pop_cmd    (c_pop_cmd)
    );

    ibs_back #(
        .T_CMD     (t_cmd),
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (c_pop_valid),
        .i_q_cmd   (c_pop_cmd),
        .o_q_pop   (c_pop),
        .o_res     (o_res)
    );
endmodule
